// ----- src/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module under src.
package rau_pkg;

  localparam int WIDTH     = 16;
  localparam int IN_W      = 16;
  localparam int ACT_W     = 3;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;
  localparam int PW        = 2 * WIDTH;
  localparam int NW        = PW + 1;
  localparam int CW        = $clog2(NW + 1);
  localparam int DEN_MIN   = 2;

  localparam logic [ACT_W-1:0] OP_REDUCE = 3'd0;
  localparam logic [ACT_W-1:0] OP_MUL    = 3'd1;
  localparam logic [ACT_W-1:0] OP_DIV    = 3'd2;
  localparam logic [ACT_W-1:0] OP_ADD    = 3'd3;
  localparam logic [ACT_W-1:0] OP_SUB    = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_stat_t;

endpackage

// ----- src/rau_gcd.sv -----
// Binary gcd unit: one compare/subtract or shift per cycle, then shift-back of common twos.
// Depends on rau_pkg.
module rau_gcd import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] x_in,
  input  logic [NW-1:0] y_in,
  output logic [NW-1:0] g,
  output rau_stat_t     stat
);

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_RUN  = 3'b010,
    G_SHL  = 3'b100
  } gstate_t;

  gstate_t       state_r, state_nxt;
  logic [NW-1:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   diff;

  assign diff = {1'b0, x_r} - {1'b0, y_r};

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    g_nxt     = g_r;
    k_nxt     = k_r;
    done_nxt  = 1'b0;
    case (state_r)
      G_IDLE: begin
        if (start) begin
          x_nxt     = x_in;
          y_nxt     = y_in;
          k_nxt     = '0;
          state_nxt = G_RUN;
        end
      end
      G_RUN: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt     = x_r | y_r;
          state_nxt = G_SHL;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + CW'(1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (!diff[NW]) begin
          x_nxt = diff[NW-1:0];
        end else begin
          y_nxt = -diff[NW-1:0];
        end
      end
      G_SHL: begin
        if (k_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = G_IDLE;
        end else begin
          g_nxt = g_r << 1;
          k_nxt = k_r - CW'(1);
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  assign g         = g_r;
  assign stat.busy = (state_r != G_IDLE);
  assign stat.done = done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == G_IDLE)
    else $error("gcd done while running");

endmodule

// ----- src/rau_div.sv -----
// Restoring divider, one quotient bit per cycle; shared for numerator and denominator.
// Depends on rau_pkg.
module rau_div import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [NW-1:0] quo,
  output rau_stat_t     stat
);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } dstate_t;

  dstate_t       state_r, state_nxt;
  logic [NW-1:0] rem_r, rem_nxt, q_r, q_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   rem_sh, trial;

  assign rem_sh = {rem_r, q_r[NW-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          rem_nxt   = '0;
          q_nxt     = dividend;
          dvs_nxt   = divisor;
          cnt_nxt   = CW'(NW);
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        if (!trial[NW]) begin
          rem_nxt = trial[NW-1:0];
          q_nxt   = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[NW-1:0];
          q_nxt   = {q_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quo       = q_r;
  assign stat.busy = (state_r != D_IDLE);
  assign stat.done = done_r;

endmodule

// ----- src/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit top: sequencer, shared multiplier, gcd and divider instances.
// Depends on rau_pkg, rau_gcd, rau_div.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    action, a_num, a_den, b_num, b_den
//   out_     output     out_valid/out_ready  res_num, res_den
//
// One transaction at a time: products through the one multiplier, then binary gcd
// steps (one shift or subtract per cycle), up to PW shift-back steps and two
// divisions, numerator then denominator; the gcd and divisions are skipped when no
// reduction applies.
// The result register frees the input side: a new transaction is taken while a
// result waits. Synchronous reset clears control state only.
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ACT_W-1:0]            in_action,
  input  logic signed [IN_W-1:0]      in_a_num,
  input  logic signed [IN_W-1:0]      in_a_den,
  input  logic signed [IN_W-1:0]      in_b_num,
  input  logic signed [IN_W-1:0]      in_b_den,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RES_NUM_W-1:0] out_res_num,
  output logic signed [RES_DEN_W-1:0] out_res_den
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DIVN = 8'b0010_0000,
    S_DIVD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ACT_W-1:0]          op_r, op_nxt;
  logic signed [WIDTH-1:0]   an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [1:0]                step_r, step_nxt;
  logic signed [NW-1:0]      num_r, num_nxt;
  logic signed [PW-1:0]      den_r, den_nxt, t_r, t_nxt;
  logic [NW-1:0]             mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic signed [RES_NUM_W-1:0] onum_r, onum_nxt;
  logic signed [RES_DEN_W-1:0] oden_r, oden_nxt;

  logic signed [WIDTH-1:0]   mx, my;
  logic signed [PW-1:0]      prod;
  logic                      in_fire, arith, reduce_ok, slot_free;
  logic                      gcd_start, div_start;
  logic [NW-1:0]             g, quo, div_a;
  rau_stat_t                 gcd_st, div_st;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !ovalid_r || out_ready;
  assign arith     = (in_action inside {OP_MUL, OP_DIV, OP_ADD, OP_SUB});
  assign reduce_ok = !den_r[PW-1] && (den_r >= PW'(DEN_MIN));

  always_comb begin
    case (step_r)
      2'd0: begin
        mx = an_r;
        my = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = ad_r;
        my = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = bn_r;
        my = ad_r;
      end
    endcase
  end
  assign prod = mx * my;

  assign gcd_start = (state_r == S_CHK) && reduce_ok;
  assign div_start = ((state_r == S_GCD) && gcd_st.done) ||
                     ((state_r == S_DIVN) && div_st.done);
  assign div_a     = (state_r == S_GCD) ? mag_r : NW'(unsigned'(den_r));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    an_nxt     = an_r;
    ad_nxt     = ad_r;
    bn_nxt     = bn_r;
    bd_nxt     = bd_r;
    step_nxt   = step_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    t_nxt      = t_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    ovalid_nxt = ovalid_r && !out_ready;
    onum_nxt   = onum_r;
    oden_nxt   = oden_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_action;
          an_nxt   = WIDTH'(in_a_num);
          ad_nxt   = WIDTH'(in_a_den);
          bn_nxt   = WIDTH'(in_b_num);
          bd_nxt   = WIDTH'(in_b_den);
          num_nxt  = NW'(signed'(WIDTH'(in_a_num)));
          den_nxt  = PW'(signed'(WIDTH'(in_a_den)));
          step_nxt = 2'd0;
          state_nxt = arith ? S_MUL : S_CHK;
        end
      end
      S_MUL: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: num_nxt = NW'(prod);
          2'd1: begin
            den_nxt = prod;
            if (op_r == OP_MUL || op_r == OP_DIV) state_nxt = S_CHK;
          end
          default: begin
            t_nxt     = prod;
            state_nxt = S_SUM;
          end
        endcase
      end
      S_SUM: begin
        num_nxt   = (op_r == OP_SUB) ? num_r - NW'(t_r) : num_r + NW'(t_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        neg_nxt   = num_r[NW-1];
        mag_nxt   = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
        state_nxt = reduce_ok ? S_GCD : S_DONE;
      end
      S_GCD: begin
        if (gcd_st.done) state_nxt = S_DIVN;
      end
      S_DIVN: begin
        if (div_st.done) begin
          num_nxt   = neg_r ? -signed'(quo) : signed'(quo);
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_st.done) begin
          den_nxt   = PW'(quo);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          onum_nxt   = RES_NUM_W'(num_r);
          oden_nxt   = RES_DEN_W'(den_r);
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r   <= op_nxt;
    an_r   <= an_nxt;
    ad_r   <= ad_nxt;
    bn_r   <= bn_nxt;
    bd_r   <= bd_nxt;
    step_r <= step_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    t_r    <= t_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    onum_r <= onum_nxt;
    oden_r <= oden_nxt;
  end

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x_in  (NW'(unsigned'(den_r))),
    .y_in  (mag_nxt),
    .g     (g),
    .stat  (gcd_st)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (g),
    .quo      (quo),
    .stat     (div_st)
  );

  assign out_valid   = ovalid_r;
  assign out_res_num = onum_r;
  assign out_res_den = oden_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("accepted a transaction but still ready");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(gcd_st.busy && div_st.busy))
    else $error("gcd and divider active together");

  a_divd_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVD) && div_st.done |=> state_r == S_DONE)
    else $error("denominator division did not finish the transaction");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && slot_free |=> ovalid_r && (state_r == S_IDLE))
    else $error("result not loaded");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rational_arithmetic_unit_core: directed table plus random
// fraction arithmetic, predicted in-bench and compared per transaction. Depends on rau_pkg.
module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic signed [IN_W-1:0] an, ad, bn, bd;
    logic chk;
    logic signed [RES_NUM_W-1:0] xn;
    logic signed [RES_DEN_W-1:0] xd;
  } row_t;

  typedef struct {
    logic signed [RES_NUM_W-1:0] n;
    logic signed [RES_DEN_W-1:0] d;
  } frac_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [ACT_W-1:0] in_action = '0;
  logic signed [IN_W-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic in_ready, out_valid;
  logic signed [RES_NUM_W-1:0] out_res_num;
  logic signed [RES_DEN_W-1:0] out_res_den;

  frac_t pending_fracs[$];
  int errors = 0, results_seen = 0, cycles = 0;
  bit hold_off = 0;

  rational_arithmetic_unit_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("%0t timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic frac_t lowest_terms(logic [ACT_W-1:0] act, logic signed [IN_W-1:0] an,
                                         logic signed [IN_W-1:0] ad,
                                         logic signed [IN_W-1:0] bn,
                                         logic signed [IN_W-1:0] bd);
    logic signed [63:0] n, d, x, y, t, m;
    frac_t r;
    case (act)
      OP_MUL: begin n = 64'(an) * 64'(bn); d = 64'(ad) * 64'(bd); end
      OP_DIV: begin n = 64'(an) * 64'(bd); d = 64'(ad) * 64'(bn); end
      OP_ADD: begin n = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad); d = 64'(ad) * 64'(bd); end
      OP_SUB: begin n = 64'(an) * 64'(bd) - 64'(bn) * 64'(ad); d = 64'(ad) * 64'(bd); end
      default: begin n = 64'(an); d = 64'(ad); end
    endcase
    if (d >= DEN_MIN) begin
      m = (n < 0) ? -n : n;
      x = d; y = m;
      while (y != 0) begin t = x % y; x = y; y = t; end
      n = n / x;
      d = d / x;
    end
    r.n = n[RES_NUM_W-1:0];
    r.d = d[RES_DEN_W-1:0];
    return r;
  endfunction

  // result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 9) < 2) out_ready <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    frac_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_fracs.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction %0d/%0d", $time, out_res_num, out_res_den);
      end else begin
        e = pending_fracs.pop_front();
        if (e.n !== out_res_num) begin
          errors++;
          $display("%0t res_num exp %0d got %0d", $time, e.n, out_res_num);
        end
        if (e.d !== out_res_den) begin
          errors++;
          $display("%0t res_den exp %0d got %0d", $time, e.d, out_res_den);
        end
      end
    end
  end

  task automatic send(row_t r);
    frac_t p;
    p = lowest_terms(r.act, r.an, r.ad, r.bn, r.bd);
    if (r.chk && (p.n !== r.xn || p.d !== r.xd)) begin
      errors++;
      $display("%0t table row exp %0d/%0d predictor %0d/%0d", $time, r.xn, r.xd, p.n, p.d);
    end
    if (r.chk) begin p.n = r.xn; p.d = r.xd; end
    in_valid <= 1'b1;
    in_action <= r.act;
    in_a_num <= r.an; in_a_den <= r.ad; in_b_num <= r.bn; in_b_den <= r.bd;
    do @(posedge clk); while (!in_ready);
    pending_fracs.push_back(p);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic logic signed [IN_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom);
      1: return IN_W'($signed($urandom_range(0, 24)) - 12);
      2: return {1'b1, (IN_W-1)'($urandom_range(0, 3))};
      3: return {1'b0, {(IN_W-1){1'b1}}} - IN_W'($urandom_range(0, 3));
      default: return IN_W'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  localparam logic signed [IN_W-1:0] MAXV = 16'sh7fff, MINV = -16'sh8000;

  row_t dir_rows[] = '{
    '{OP_REDUCE, 6, 4, 0, 0, 1, 3, 2},
    '{OP_REDUCE, 0, 5, 0, 0, 1, 0, 1},
    '{OP_REDUCE, 6, 1, 0, 0, 1, 6, 1},
    '{OP_REDUCE, 6, 0, 0, 0, 1, 6, 0},
    '{OP_REDUCE, 4, -2, 0, 0, 1, 4, -2},
    '{OP_MUL, 2, 3, 3, 4, 1, 1, 2},
    '{OP_DIV, 1, 2, 0, 3, 1, 3, 0},
    '{OP_DIV, 2, 3, 4, 9, 1, 3, 2},
    '{OP_ADD, 1, 2, 1, 3, 1, 5, 6},
    '{OP_SUB, 1, 2, 1, 2, 1, 0, 1},
    '{3'd5, 10, 4, 1, 1, 1, 5, 2},
    '{3'd6, -10, 4, 1, 1, 1, -5, 2},
    '{3'd7, 7, 7, 1, 1, 1, 1, 1},
    '{OP_MUL, MINV, MINV, MINV, MINV, 0, 0, 0},
    '{OP_MUL, MAXV, MAXV, MINV, MAXV, 0, 0, 0},
    '{OP_ADD, MINV, MAXV, MINV, MAXV, 0, 0, 0},
    '{OP_SUB, MINV, MAXV, MAXV, MINV, 0, 0, 0},
    '{OP_DIV, MAXV, MINV, MINV, -1, 0, 0, 0},
    '{OP_REDUCE, MINV, MAXV, 0, 0, 0, 0, 0},
    '{OP_ADD, -1, -1, -1, -1, 0, 0, 0}
  };

  initial begin
    row_t r;
    int n_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i]);
    n_items = dir_rows.size();
    for (int k = 0; k < 1300; k++) begin
      if (k == 300) begin
        in_valid <= 1'b0;
        while (pending_fracs.size() != 0) @(posedge clk);
      end
      if (k == 600) fork
        begin
          hold_off = 1;
          repeat (400) @(posedge clk);
          hold_off = 0;
        end
      join_none
      r.act = ($urandom_range(0, 19) == 0) ? ACT_W'($urandom_range(5, 7))
                                          : ACT_W'($urandom_range(0, 4));
      r.an = rand_val(); r.ad = rand_val(); r.bn = rand_val(); r.bd = rand_val();
      r.chk = 1'b0; r.xn = '0; r.xd = '0;
      send(r);
      n_items++;
    end
    in_valid <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d fraction transactions (reduce/mul/div/add/sub, unused codes, extremes),",
             n_items);
    $display("%0d results compared, %0d mismatches.", results_seen, errors);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
